// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the lfu cache top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define LFU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define LFU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/lfu_pkg.sv =====
// shared types and constants of the lfu cache
`default_nettype none

package lfu_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned KEY_PORT_W = 32;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 1;

  localparam logic [CAP_W-1:0]      CAP_RESET     = 5'd16;
  localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 1'b0;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam logic [DATA_W-1:0] READ_MISS = '1;

  // per-entry decision of the scan comparator
  typedef struct packed {
    logic hit;
    logic take_victim;
    logic take_free;
  } lfu_cmp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfu_cache_with_lru_tiebreak.sv =====
// lfu key-value cache with lru tie-break, serial scan over the entry memories
// a request is scanned against every entry, then updated; the result is registered
// one request at a time: a new one is taken only in idle, the update waits for a free result slot; the scan reads one
//   entry per cycle from the entry memories through the single comparator
// reset: valid bits and occupancy clear at once, capacity returns to 16, no clearing pass
`default_nettype none
`include "assert_macros.svh"

module lfu_cache_with_lru_tiebreak import lfu_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [KEY_PORT_W-1:0]   req_key_i,
  input  logic signed [DATA_W-1:0] req_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic                    evicted_o,
  output logic [KEY_PORT_W-1:0]   evicted_key_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_e;

  state_e state_q;

  // configuration
  logic [CAP_W-1:0] capacity_q;
  logic [OCC_W-1:0] cap_eff;

  // entry storage
  logic [KEY_BITS-1:0]   key_mem [MAX_ENTRIES];
  logic [DATA_W-1:0]     val_mem [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]      rank_q  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [OCC_W-1:0]      occ_q;

  // request
  logic                req_type_q;
  logic [KEY_BITS-1:0] req_key_q;
  logic [DATA_W-1:0]   req_val_q;

  // scan pipeline
  logic [IDX_W-1:0]      idx_q;
  logic                  issue_done_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  rd_valid_q;
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [DATA_W-1:0]     rd_val_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic [IDX_W-1:0]      rd_rank_q;
  logic                  scan_rd;

  // running scan results
  logic                  found_q;
  logic [IDX_W-1:0]      m_idx_q;
  logic [DATA_W-1:0]     m_val_q;
  logic [COUNT_BITS-1:0] m_cnt_q;
  logic [IDX_W-1:0]      m_rank_q;
  logic                  vf_q;
  logic [IDX_W-1:0]      v_idx_q;
  logic [COUNT_BITS-1:0] v_cnt_q;
  logic [IDX_W-1:0]      v_rank_q;
  logic [KEY_BITS-1:0]   v_key_q;
  logic                  ff_q;
  logic [IDX_W-1:0]      f_idx_q;
  lfu_cmp_t              flags;

  // result registers
  logic                out_valid_q;
  logic                out_hit_q;
  logic [DATA_W-1:0]   out_rd_q;
  logic                out_ev_q;
  logic [KEY_PORT_W-1:0] out_evk_q;

  // update decision
  logic                  upd_go;
  logic                  wr_en;
  logic                  ins;
  logic                  age_all;
  logic [IDX_W-1:0]      wr_idx;
  logic [DATA_W-1:0]     wr_val;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [IDX_W-1:0]      old_rank;
  logic                  res_hit;
  logic [DATA_W-1:0]     res_rd;
  logic                  res_ev;
  logic [KEY_PORT_W-1:0] res_evk;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? APB_DATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  assign cap_eff = (32'(capacity_q) > MAX_ENTRIES) ? OCC_W'(MAX_ENTRIES) : OCC_W'(capacity_q);

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign read_value_o  = out_rd_q;
  assign evicted_o     = out_ev_q;
  assign evicted_key_o = out_evk_q;

  assign scan_rd = (state_q == ST_SCAN) && !issue_done_q;

  lfu_cmp #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .RANK_W     (IDX_W)
  ) u_cmp (
    .ent_valid_i  (rd_valid_q),
    .ent_key_i    (rd_key_q),
    .ent_cnt_i    (rd_cnt_q),
    .ent_rank_i   (rd_rank_q),
    .req_key_i    (req_key_q),
    .found_i      (found_q),
    .vic_found_i  (vf_q),
    .vic_cnt_i    (v_cnt_q),
    .vic_rank_i   (v_rank_q),
    .free_found_i (ff_q),
    .flags_o      (flags)
  );

  always_comb begin
    upd_go   = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);
    res_hit  = 1'b0;
    res_rd   = '0;
    res_ev   = 1'b0;
    res_evk  = '0;
    ins      = 1'b0;
    wr_en    = 1'b0;
    age_all  = 1'b0;
    wr_idx   = m_idx_q;
    wr_val   = m_val_q;
    old_rank = m_rank_q;
    if (req_type_q == REQ_GET) begin
      if (found_q) begin
        res_hit = 1'b1;
        res_rd  = m_val_q;
        wr_en   = 1'b1;
      end else begin
        res_rd  = READ_MISS;
      end
    end else if (cap_eff != '0) begin
      if (found_q) begin
        res_hit = 1'b1;
        wr_en   = 1'b1;
        wr_val  = req_val_q;
      end else if ((occ_q >= cap_eff) && vf_q) begin
        res_ev   = 1'b1;
        res_evk  = KEY_PORT_W'(v_key_q);
        ins      = 1'b1;
        wr_en    = 1'b1;
        wr_idx   = v_idx_q;
        wr_val   = req_val_q;
        old_rank = v_rank_q;
      end else if (ff_q) begin
        ins     = 1'b1;
        wr_en   = 1'b1;
        wr_idx  = f_idx_q;
        wr_val  = req_val_q;
        age_all = 1'b1;
      end
    end
    if (ins) begin
      wr_cnt = CNT_ONE;
    end else if (m_cnt_q == CNT_MAX) begin
      wr_cnt = m_cnt_q;
    end else begin
      wr_cnt = m_cnt_q + CNT_ONE;
    end
  end

  // entry memories: one scan read port, one write port
  always_ff @(posedge clk_i) begin
    if (scan_rd) begin
      rd_key_q   <= key_mem[idx_q];
      rd_val_q   <= val_mem[idx_q];
      rd_cnt_q   <= cnt_mem[idx_q];
      rd_rank_q  <= rank_q[idx_q];
      rd_valid_q <= valid_q[idx_q];
      rd_idx_q   <= idx_q;
    end
    if (upd_go && wr_en) begin
      key_mem[wr_idx] <= req_key_q;
      val_mem[wr_idx] <= wr_val;
      cnt_mem[wr_idx] <= wr_cnt;
    end
  end

  // recency ranks age in parallel on a touch or insert
  always_ff @(posedge clk_i) begin
    if (upd_go && wr_en) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == wr_idx) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (age_all || (rank_q[i] < old_rank))) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end
  end

  // payload of the request and the scan winners
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_type_q <= req_type_i;
      req_key_q  <= KEY_BITS'(req_key_i);
      req_val_q  <= req_value_i;
    end
    if (rd_vld_q && (state_q == ST_SCAN)) begin
      if (flags.hit) begin
        m_idx_q  <= rd_idx_q;
        m_val_q  <= rd_val_q;
        m_cnt_q  <= rd_cnt_q;
        m_rank_q <= rd_rank_q;
      end
      if (flags.take_victim) begin
        v_idx_q  <= rd_idx_q;
        v_cnt_q  <= rd_cnt_q;
        v_rank_q <= rd_rank_q;
        v_key_q  <= rd_key_q;
      end
      if (flags.take_free) begin
        f_idx_q <= rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      vf_q         <= 1'b0;
      ff_q         <= 1'b0;
      valid_q      <= '0;
      occ_q        <= '0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_rd_q     <= '0;
      out_ev_q     <= 1'b0;
      out_evk_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !upd_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q      <= ST_SCAN;
            idx_q        <= '0;
            issue_done_q <= 1'b0;
            rd_vld_q     <= 1'b0;
            found_q      <= 1'b0;
            vf_q         <= 1'b0;
            ff_q         <= 1'b0;
          end
        end
        ST_SCAN: begin
          rd_vld_q <= scan_rd;
          if (scan_rd) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == LAST_IDX) begin
              issue_done_q <= 1'b1;
            end
          end
          if (rd_vld_q) begin
            if (flags.hit) begin
              found_q <= 1'b1;
            end
            if (flags.take_victim) begin
              vf_q <= 1'b1;
            end
            if (flags.take_free) begin
              ff_q <= 1'b1;
            end
            if (rd_idx_q == LAST_IDX) begin
              state_q <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            out_hit_q   <= res_hit;
            out_rd_q    <= res_rd;
            out_ev_q    <= res_ev;
            out_evk_q   <= res_evk;
            if (ins) begin
              valid_q[wr_idx] <= 1'b1;
              if (!res_ev) begin
                occ_q <= occ_q + 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `LFU_ASSERT(a_occ_matches_valid, 32'(occ_q) == $countones(valid_q), "occupancy off")
  `LFU_ASSERT(a_busy_after_transfer, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready right after request transfer")
  `LFU_ASSERT(a_evict_not_hit, (out_valid_o && evicted_o) |-> !hit_o, "eviction reported on a hit")
  `LFU_ASSERT(a_evict_key_zero, (out_valid_o && !evicted_o) |-> (evicted_key_o == '0), "evicted key without eviction")

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_cmp.sv =====
// scan comparator: key match, victim order and free slot test for one entry
`default_nettype none

module lfu_cmp import lfu_pkg::*; #(
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned RANK_W     = 4
) (
  input  logic                  ent_valid_i,
  input  logic [KEY_BITS-1:0]   ent_key_i,
  input  logic [COUNT_BITS-1:0] ent_cnt_i,
  input  logic [RANK_W-1:0]     ent_rank_i,
  input  logic [KEY_BITS-1:0]   req_key_i,
  input  logic                  found_i,
  input  logic                  vic_found_i,
  input  logic [COUNT_BITS-1:0] vic_cnt_i,
  input  logic [RANK_W-1:0]     vic_rank_i,
  input  logic                  free_found_i,
  output lfu_cmp_t              flags_o
);

  always_comb begin
    flags_o.hit         = ent_valid_i && !found_i && (ent_key_i == req_key_i);
    flags_o.take_victim = ent_valid_i &&
                          (!vic_found_i || (ent_cnt_i < vic_cnt_i) ||
                           ((ent_cnt_i == vic_cnt_i) && (ent_rank_i > vic_rank_i)));
    flags_o.take_free   = !ent_valid_i && !free_found_i;
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the lfu cache: directed table and random requests checked against a predictor
module tb import lfu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = MAX_ENTRIES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int STALL_PCT [4] = '{0, 25, 60, 85};
  localparam logic [CAP_W-1:0] PHASE_CAP [7] = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17};

  typedef struct packed {
    logic                     hit;
    logic [DATA_W-1:0]        read_value;
    logic                     evicted;
    logic [KEY_PORT_W-1:0]    evicted_key;
  } answer_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic                     req;
    logic [KEY_PORT_W-1:0]    key;
    logic [DATA_W-1:0]        value;
    int                       reps;
    logic                     typed;
    answer_t                  want;
  } row_t;

  localparam answer_t QUIET = '0;
  localparam answer_t MISS = '{1'b0, READ_MISS, 1'b0, 32'h0};
  localparam logic [31:0] KEY_A = 32'h1234_5678;
  localparam logic [31:0] KEY_B = 32'h0F0F_0F0F;
  localparam logic [31:0] KEY_C = 32'hF0F0_F0F0;

  // cap rows carry the capacity in the value column
  localparam row_t PLAN [30] = '{
    '{ROW_CAP, REQ_GET, 32'h0, 32'd2, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, KEY_A, 32'h11, 1, 1'b1, QUIET},
    '{ROW_REQ, REQ_GET, KEY_A, 32'h0, 3, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, KEY_B, 32'h22, 1, 1'b1, QUIET},
    '{ROW_REQ, REQ_PUT, KEY_C, 32'h33, 1, 1'b1, '{1'b0, 32'h0, 1'b1, KEY_B}},
    '{ROW_REQ, REQ_GET, KEY_A, 32'h0, 1, 1'b1, '{1'b1, 32'h11, 1'b0, 32'h0}},
    '{ROW_REQ, REQ_GET, KEY_B, 32'h0, 1, 1'b1, MISS},
    '{ROW_CAP, REQ_GET, 32'h0, 32'd16, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_GET, 32'h0, 32'h0, 1, 1'b1, MISS},
    '{ROW_REQ, REQ_PUT, 32'h0, 32'h8000_0000, 1, 1'b1, QUIET},
    '{ROW_REQ, REQ_GET, 32'h0, 32'h0, 1, 1'b1, '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    '{ROW_REQ, REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1'b1, QUIET},
    '{ROW_REQ, REQ_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{ROW_REQ, REQ_PUT, 32'h0, 32'hFFFF_FFFF, 1, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_REQ, REQ_GET, 32'h0, 32'h0, 1, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_CAP, REQ_GET, 32'h0, 32'd0, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, 32'h5, 32'h1, 1, 1'b1, QUIET},
    '{ROW_REQ, REQ_GET, 32'h5, 32'h0, 1, 1'b1, MISS},
    '{ROW_REQ, REQ_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{ROW_CAP, REQ_GET, 32'h0, 32'd1, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, 32'h6, 32'h2, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, 32'h7, 32'h3, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_GET, 32'h6, 32'h0, 1, 1'b0, QUIET},
    '{ROW_CAP, REQ_GET, 32'h0, 32'd31, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, 32'h8, 32'h4, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, 32'h9, 32'h5, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_PUT, 32'h9, 32'h5555_5555, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_GET, 32'h9, 32'h0, 1, 1'b0, QUIET},
    '{ROW_REQ, REQ_GET, 32'h0, 32'h0, 1, 1'b0, QUIET},
    '{ROW_CAP, REQ_GET, 32'h0, 32'd16, 1, 1'b0, QUIET}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    req_type_i = 1'b0;
  logic [KEY_PORT_W-1:0]   req_key_i = '0;
  logic signed [DATA_W-1:0] req_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    hit_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic                    evicted_o;
  logic [KEY_PORT_W-1:0]   evicted_key_o;

  // predictor state
  logic [CAP_W-1:0]        capacity_now = CAP_RESET;
  bit                      slot_used [DEPTH];
  logic [KEY_PORT_W-1:0]   slot_key [DEPTH];
  logic [DATA_W-1:0]       slot_val [DEPTH];
  logic [15:0]             use_cnt [DEPTH];
  int unsigned             age_rank [DEPTH];
  int unsigned             fill = 0;

  answer_t                 pending_answers [$];
  answer_t                 head;
  logic [KEY_PORT_W-1:0]   key_pool [24];
  int                      mismatches = 0;
  int                      burst_left = 0;
  int                      quiet = 0;
  int unsigned             beat = 0;
  bit                      rush = 1'b0;

  lfu_cache_with_lru_tiebreak uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .req_type_i, .req_key_i, .req_value_i,
    .out_valid_o, .out_ready_i, .hit_o, .read_value_o, .evicted_o, .evicted_key_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void refresh_entry(int s);
    int unsigned old;
    old = age_rank[s];
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && i != s && age_rank[i] < old) age_rank[i]++;
    age_rank[s] = 0;
    if (use_cnt[s] != 16'hFFFF) use_cnt[s]++;
  endfunction

  function automatic int least_used();
    int v;
    v = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i]) begin
        if (v < 0) v = i;
        else if (use_cnt[i] < use_cnt[v]) v = i;
        else if (use_cnt[i] == use_cnt[v] && age_rank[i] > age_rank[v]) v = i;
      end
    end
    return v;
  endfunction

  function automatic answer_t serve_request(logic rq, logic [31:0] k, logic [31:0] v);
    answer_t a;
    int s;
    int slot;
    int vic;
    int unsigned eff;
    int unsigned old;
    a = '0;
    s = -1;
    slot = -1;
    eff = (capacity_now > DEPTH) ? DEPTH : capacity_now;
    for (int i = 0; i < DEPTH; i++)
      if (s < 0 && slot_used[i] && slot_key[i] == k) s = i;
    if (rq == REQ_GET) begin
      if (s >= 0) begin
        a.hit = 1'b1;
        a.read_value = slot_val[s];
        refresh_entry(s);
      end else begin
        a.read_value = READ_MISS;
      end
    end else if (eff != 0) begin
      if (s >= 0) begin
        a.hit = 1'b1;
        slot_val[s] = v;
        refresh_entry(s);
      end else begin
        if (fill >= eff) begin
          vic = least_used();
          if (vic >= 0) begin
            a.evicted = 1'b1;
            a.evicted_key = slot_key[vic];
            old = age_rank[vic];
            slot_used[vic] = 1'b0;
            for (int i = 0; i < DEPTH; i++)
              if (slot_used[i] && age_rank[i] > old) age_rank[i]--;
            if (fill > 0) fill--;
            slot = vic;
          end
        end
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < DEPTH; i++)
            if (slot_used[i]) age_rank[i]++;
          slot_used[slot] = 1'b1;
          slot_key[slot] = k;
          slot_val[slot] = v;
          use_cnt[slot] = 16'd1;
          age_rank[slot] = 0;
          fill++;
        end
      end
    end
    return a;
  endfunction

  task automatic send_request(input logic rq, input logic [31:0] k, input logic [31:0] v,
                              input logic typed, input answer_t want, input bit nogap);
    answer_t guess;
    if (!nogap) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq;
    req_key_i <= k;
    req_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    guess = serve_request(rq, k, v);
    pending_answers.push_back(typed ? want : guess);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CAPACITY;
    pwdata <= APB_DATA_W'(c);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CAP_W-1:0] !== c)
      flag_error($sformatf("capacity readback: expected %0d, got %0d", c, prdata[CAP_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
    capacity_now = c;
    @(posedge clk_i);
  endtask

  initial begin
    int span;
    logic [31:0] k;
    logic rq;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < 30; r++) begin
      if (PLAN[r].kind == ROW_CAP) begin
        write_capacity(PLAN[r].value[CAP_W-1:0]);
      end else begin
        // long repeats run with no idling on either side
        rush = PLAN[r].reps > 1;
        repeat (PLAN[r].reps)
          send_request(PLAN[r].req, PLAN[r].key, PLAN[r].value, PLAN[r].typed,
                       PLAN[r].want, rush);
        rush = 1'b0;
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(ph < 7 ? PHASE_CAP[ph] : CAP_W'($urandom_range(0, 31)));
      span = int'(capacity_now) + 5;
      if (span > 24) span = 24;
      repeat (88) begin
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, span - 1)];
        rq = $urandom_range(0, 1);
        send_request(rq, k, $urandom, 1'b0, QUIET, 1'b0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    beat <= beat + 1;
    out_ready_i <= rush || ($urandom_range(0, 99) >= STALL_PCT[beat[9:8]]);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        flag_error($sformatf("result transfer with nothing expected: hit %0b value %h",
                             hit_o, read_value_o));
      end else begin
        head = pending_answers.pop_front();
        if (hit_o !== head.hit || read_value_o !== head.read_value ||
            evicted_o !== head.evicted || evicted_key_o !== head.evicted_key)
          flag_error($sformatf({"result mismatch: expected hit %0b value %h evicted %0b key %h,",
                                " got hit %0b value %h evicted %0b key %h"},
                               head.hit, head.read_value, head.evicted, head.evicted_key,
                               hit_o, read_value_o, evicted_o, evicted_key_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
